[hdl/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication under synchronous reset
`define DTE_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dte assertion failed");

// next-cycle implication under synchronous reset
`define DTE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dte assertion failed");

`endif

[hdl/dte_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package dte_pkg;

   localparam int RADIUS    = 7;
   localparam int MAX_WIDTH = 2048;
   localparam int WIN_ROWS  = 2 * RADIUS + 1;
   localparam int MAX_W_CAP = (MAX_WIDTH < 2048) ? MAX_WIDTH : 2048;
   localparam int SLOT_W    = $clog2(WIN_ROWS + 1);
   localparam int DEPTH     = WIN_ROWS * MAX_WIDTH;
   localparam int ADDR_W    = $clog2(DEPTH);
   localparam int VAL_W     = 24;
   localparam int IN_W      = 24;
   localparam int OUT_W     = 40;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_W     = 17;
   localparam logic [VAL_W-1:0] MIN_START = VAL_W'(255 * 65536);
   localparam logic [16:0] Q_ONE = 17'h10000;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_FRAME_WIDTH  = 3'd0,
      REG_FRAME_HEIGHT = 3'd1,
      REG_INV_BLUE     = 3'd2,
      REG_INV_GREEN    = 3'd3,
      REG_INV_RED      = 3'd4,
      REG_HAZE_KEEP    = 3'd5
   } csr_reg_type;

   function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
      return (32'(s) == WIN_ROWS - 1) ? '0 : SLOT_W'(32'(s) + 1);
   endfunction

   // slot of the row RADIUS rows above
   function automatic logic [SLOT_W-1:0] slot_back(input logic [SLOT_W-1:0] s);
      return (32'(s) >= RADIUS) ? SLOT_W'(32'(s) - RADIUS)
                                : SLOT_W'(32'(s) + WIN_ROWS - RADIUS);
   endfunction

   function automatic logic [ADDR_W-1:0] line_addr(input logic [SLOT_W-1:0] s,
                                                   input logic [10:0] col);
      return ADDR_W'(32'(s) * MAX_WIDTH + 32'(col));
   endfunction

   function automatic logic [16:0] sat_q(input logic [16:0] v);
      return (v > Q_ONE) ? Q_ONE : v;
   endfunction

endpackage
`default_nettype wire

[hdl/dte_line_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
module dte_line_ram #(
   parameter int DATA_W = 24,
   parameter int DEPTH  = 30720,
   parameter int ADDR_W = 15
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [DATA_W-1:0] wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [0:DEPTH-1];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

[hdl/dehaze_transmission_estimate_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// Dark channel transmission estimate over a pixel stream in raster order.
// req: one pixel per request, tdata = blue, green, red (8 bits each).
// rsp: zero or more results per pixel, tdata = row, column, transmission
// (Q1.16), tlast marks the last result of a pixel, tuser the frame's last.
// csr: register writes (index, data), always ready; write only while idle.
// One pixel is handled at a time. A pixel that completes no window goes
// from S_SCALE straight to S_FIN. Each result scans its window (up to
// 15x15) and then waits for rsp_tready. The window is scanned through the
// single read port of the line store, one entry per cycle for every result.
// Reset clears the position counters and the registers; the line store is
// not cleared, every entry is written before it is read.
// When the receiver stalls the result is held in the output register and
// the block takes no new pixel until it is taken.
module dehaze_transmission_estimate_top import dte_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic [IN_W-1:0]      req_tdata,   // blue, green, red
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic [OUT_W-1:0]          rsp_tdata,   // out_row, out_col, transmission
   output logic                      rsp_tlast,
   output logic [0:0]                rsp_tuser,   // frame_end
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_W-1:0]     csr_data
);

   typedef enum logic [3:0] {
      S_IDLE, S_SCALE, S_WIN, S_SCAN, S_DRAIN, S_MUL, S_RND, S_OUT, S_FIN
   } state_type;

   state_type state_ff;

   logic [11:0] frame_width_ff;
   logic [12:0] frame_height_ff;
   logic [16:0] inv_blue_ff, inv_green_ff, inv_red_ff, haze_ff;

   logic [11:0]       row_ff;
   logic [10:0]       col_ff;
   logic [SLOT_W-1:0] slot_ff;

   logic [IN_W-1:0]   px_ff;
   logic [11:0]       i_ff;
   logic [10:0]       j_ff;
   logic [SLOT_W-1:0] slot_i_ff;
   logic [11:0]       w_ff;
   logic [12:0]       h_ff;

   logic [11:0]       r_ff, r1_ff, wr1_ff, x_ff;
   logic [10:0]       c_ff, c0_ff, c1_ff, wc0_ff, wc1_ff, y_ff;
   logic [SLOT_W-1:0] rslot_ff, xslot_ff;
   logic              last_pix_ff;
   logic [VAL_W-1:0]  acc_ff;
   logic              rd_pend_ff;
   logic [40:0]       prod_ff;

   logic              rsp_valid_ff, rsp_last_ff, rsp_end_ff;
   logic [11:0]       rsp_row_ff;
   logic [10:0]       rsp_col_ff;
   logic [16:0]       rsp_trans_ff;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= 12'd1;
         frame_height_ff <= 13'd1;
         inv_blue_ff     <= 17'd257;
         inv_green_ff    <= 17'd257;
         inv_red_ff      <= 17'd257;
         haze_ff         <= 17'd62259;
      end else if (csr_valid) begin
         unique case (csr_reg_type'(csr_index))
            REG_FRAME_WIDTH:  frame_width_ff  <= csr_data[11:0];
            REG_FRAME_HEIGHT: frame_height_ff <= csr_data[12:0];
            REG_INV_BLUE:     inv_blue_ff     <= sat_q(csr_data);
            REG_INV_GREEN:    inv_green_ff    <= sat_q(csr_data);
            REG_INV_RED:      inv_red_ff      <= sat_q(csr_data);
            REG_HAZE_KEEP:    haze_ff         <= sat_q(csr_data);
            default: ;
         endcase
      end
   end

   assign csr_ready = 1'b1;

   // effective frame size
   logic [11:0] w_cfg;
   logic [12:0] h_cfg;
   assign w_cfg = (frame_width_ff == '0) ? 12'd1 :
                  (32'(frame_width_ff) > MAX_W_CAP) ? 12'(MAX_W_CAP) : frame_width_ff;
   assign h_cfg = (frame_height_ff == '0) ? 13'd1 :
                  (frame_height_ff > 13'd4096) ? 13'd4096 : frame_height_ff;

   // position of the incoming pixel, wrapped against the current size
   logic              col_wrap, row_wrap;
   logic [12:0]       row_step;
   logic [SLOT_W-1:0] slot_step;
   logic [11:0]       i_in;
   logic [10:0]       j_in;
   logic [SLOT_W-1:0] slot_i_in;
   assign col_wrap  = {1'b0, col_ff} >= w_cfg;
   assign row_step  = col_wrap ? {1'b0, row_ff} + 13'd1 : {1'b0, row_ff};
   assign slot_step = col_wrap ? slot_inc(slot_ff) : slot_ff;
   assign row_wrap  = row_step >= h_cfg;
   assign i_in      = row_wrap ? '0 : row_step[11:0];
   assign slot_i_in = row_wrap ? '0 : slot_step;
   assign j_in      = col_wrap ? '0 : col_ff;

   // scaled minimum of the three channels
   logic [24:0]      prod_b, prod_g, prod_r;
   logic [VAL_W-1:0] min_bg, min_val;
   assign prod_b  = 25'(px_ff[7:0])   * 25'(inv_blue_ff);
   assign prod_g  = 25'(px_ff[15:8])  * 25'(inv_green_ff);
   assign prod_r  = 25'(px_ff[23:16]) * 25'(inv_red_ff);
   assign min_bg  = (prod_g < prod_b) ? prod_g[VAL_W-1:0] : prod_b[VAL_W-1:0];
   assign min_val = (VAL_W'(prod_r) < min_bg) ? prod_r[VAL_W-1:0] : min_bg;

   // results released by this pixel
   logic        i_ge, j_ge, last_row, last_col, any_res;
   logic [11:0] r0;
   logic [10:0] c0;
   assign i_ge     = 32'(i_ff) >= RADIUS;
   assign j_ge     = 32'(j_ff) >= RADIUS;
   assign last_row = {1'b0, i_ff} == (h_ff - 13'd1);
   assign last_col = {1'b0, j_ff} == (w_ff - 12'd1);
   assign r0       = i_ge ? 12'(32'(i_ff) - RADIUS) : '0;
   assign c0       = j_ge ? 11'(32'(j_ff) - RADIUS) : '0;
   assign any_res  = (last_row || i_ge) && (last_col || j_ge);

   // window of the current result, clipped at the borders
   logic              r_ge, c_ge;
   logic [11:0]       wr0;
   logic [10:0]       wc0;
   logic [12:0]       r_hi;
   logic [11:0]       c_hi;
   logic [11:0]       wr1;
   logic [10:0]       wc1;
   logic [SLOT_W-1:0] wr0_slot;
   assign r_ge     = 32'(r_ff) >= RADIUS;
   assign c_ge     = 32'(c_ff) >= RADIUS;
   assign wr0      = r_ge ? 12'(32'(r_ff) - RADIUS) : '0;
   assign wc0      = c_ge ? 11'(32'(c_ff) - RADIUS) : '0;
   assign wr0_slot = r_ge ? slot_back(rslot_ff) : '0;
   assign r_hi     = 13'(32'(r_ff) + RADIUS);
   assign c_hi     = 12'(32'(c_ff) + RADIUS);
   assign wr1      = (r_hi > h_ff - 13'd1) ? 12'(h_ff - 13'd1) : r_hi[11:0];
   assign wc1      = (c_hi > w_ff - 12'd1) ? 11'(w_ff - 12'd1) : c_hi[10:0];

   // rounding of omega * min, and transmission as one minus it, floored at zero
   logic [41:0] prod_rnd;
   logic [25:0] t_val;
   logic [16:0] trans;
   assign prod_rnd = {1'b0, prod_ff} + 42'd32768;
   assign t_val    = prod_rnd[41:16];
   assign trans    = (t_val >= 26'(Q_ONE)) ? '0 : 17'(26'(Q_ONE) - t_val);

   // end-of-pixel counter advance
   logic [11:0] col_next;
   logic [12:0] row_next;
   assign col_next = {1'b0, j_ff} + 12'd1;
   assign row_next = {1'b0, i_ff} + 13'd1;

   // line store
   logic             ram_wr_en, ram_rd_en;
   logic [VAL_W-1:0] ram_rd_data;
   assign ram_wr_en = state_ff == S_SCALE;
   assign ram_rd_en = state_ff == S_SCAN;

   dte_line_ram #(
      .DATA_W(VAL_W),
      .DEPTH (DEPTH),
      .ADDR_W(ADDR_W)
   ) u_line_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(line_addr(slot_i_ff, j_ff)),
      .wr_data(min_val),
      .rd_en  (ram_rd_en),
      .rd_addr(line_addr(xslot_ff, y_ff)),
      .rd_data(ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         row_ff       <= '0;
         col_ff       <= '0;
         slot_ff      <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_pend_ff <= state_ff == S_SCAN;
         if (rd_pend_ff && ram_rd_data < acc_ff) begin
            acc_ff <= ram_rd_data;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  px_ff     <= req_tdata;
                  i_ff      <= i_in;
                  j_ff      <= j_in;
                  slot_i_ff <= slot_i_in;
                  w_ff      <= w_cfg;
                  h_ff      <= h_cfg;
                  state_ff  <= S_SCALE;
               end
            end
            S_SCALE: begin
               r_ff        <= r0;
               rslot_ff    <= i_ge ? slot_back(slot_i_ff) : '0;
               r1_ff       <= last_row ? i_ff : r0;
               c_ff        <= c0;
               c0_ff       <= c0;
               c1_ff       <= last_col ? j_ff : c0;
               last_pix_ff <= last_row && last_col;
               state_ff    <= any_res ? S_WIN : S_FIN;
            end
            S_WIN: begin
               x_ff     <= wr0;
               xslot_ff <= wr0_slot;
               wr1_ff   <= wr1;
               y_ff     <= wc0;
               wc0_ff   <= wc0;
               wc1_ff   <= wc1;
               acc_ff   <= MIN_START;
               state_ff <= S_SCAN;
            end
            S_SCAN: begin
               if (y_ff == wc1_ff) begin
                  y_ff <= wc0_ff;
                  if (x_ff == wr1_ff) begin
                     state_ff <= S_DRAIN;
                  end else begin
                     x_ff     <= x_ff + 12'd1;
                     xslot_ff <= slot_inc(xslot_ff);
                  end
               end else begin
                  y_ff <= y_ff + 11'd1;
               end
            end
            S_DRAIN: begin
               // last read folds into acc_ff this cycle
               state_ff <= S_MUL;
            end
            S_MUL: begin
               prod_ff  <= 41'(haze_ff) * 41'(acc_ff);
               state_ff <= S_RND;
            end
            S_RND: begin
               rsp_row_ff   <= r_ff;
               rsp_col_ff   <= c_ff;
               rsp_trans_ff <= trans;
               rsp_last_ff  <= (r_ff == r1_ff) && (c_ff == c1_ff);
               rsp_end_ff   <= (r_ff == r1_ff) && (c_ff == c1_ff) && last_pix_ff;
               rsp_valid_ff <= 1'b1;
               state_ff     <= S_OUT;
            end
            S_OUT: begin
               if (rsp_tready) begin
                  rsp_valid_ff <= 1'b0;
                  if (rsp_last_ff) begin
                     state_ff <= S_FIN;
                  end else if (c_ff == c1_ff) begin
                     c_ff     <= c0_ff;
                     r_ff     <= r_ff + 12'd1;
                     rslot_ff <= slot_inc(rslot_ff);
                     state_ff <= S_WIN;
                  end else begin
                     c_ff     <= c_ff + 11'd1;
                     state_ff <= S_WIN;
                  end
               end
            end
            S_FIN: begin
               if (col_next >= w_ff) begin
                  col_ff <= '0;
                  if (row_next >= h_ff) begin
                     row_ff  <= '0;
                     slot_ff <= '0;
                  end else begin
                     row_ff  <= row_next[11:0];
                     slot_ff <= slot_inc(slot_i_ff);
                  end
               end else begin
                  col_ff  <= col_next[10:0];
                  row_ff  <= i_ff;
                  slot_ff <= slot_i_ff;
               end
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_tready   = state_ff == S_IDLE;
   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = {rsp_trans_ff, rsp_col_ff, rsp_row_ff};
   assign rsp_tlast    = rsp_last_ff;
   assign rsp_tuser[0] = rsp_end_ff;

endmodule
`default_nettype wire

[hdl/dte_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module dte_checker import dte_pkg::*; (
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 req_tvalid,
   input wire logic                 req_tready,
   input wire logic                 rsp_tvalid,
   input wire logic                 rsp_tready,
   input wire logic [OUT_W-1:0]     rsp_tdata,
   input wire logic                 rsp_tlast,
   input wire logic [0:0]           rsp_tuser
);

   `DTE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
   `DTE_ASSERT_NEXT(a_req_busy, clock, reset, req_tvalid && req_tready, !req_tready)
   `DTE_ASSERT_IMPLIES(a_one_side, clock, reset, rsp_tvalid, !req_tready)
   `DTE_ASSERT_IMPLIES(a_end_is_last, clock, reset, rsp_tvalid && rsp_tuser[0], rsp_tlast)
   `DTE_ASSERT_IMPLIES(a_trans_range, clock, reset, rsp_tvalid, rsp_tdata[39:23] <= Q_ONE)

endmodule

bind dehaze_transmission_estimate_top dte_checker u_dte_checker (.*);
`default_nettype wire
